FILE: rtl/spim0_pkg.sv
// Shared definitions for the SPI mode 0 master shifter: sizes, codes, result beat.
// No dependencies; imported by the top level.

package spim0_pkg;

    // Sizes
    localparam int MaxBits = 64;
    localparam int CsLines = 8;
    localparam int DataW   = 64;
    localparam int CountW  = 7;
    localparam int PosW    = $clog2(MaxBits);
    localparam int HalfW   = 16;
    localparam int MaskW   = 8;
    localparam int CfgIdxW = 1;

    // Transfer data bits that exist, and select lines that exist
    localparam logic [DataW-1:0] DataMask = {DataW{1'b1}} >> (DataW - MaxBits);
    localparam logic [MaskW-1:0] CsMask   = MaskW'((1 << CsLines) - 1);
    localparam logic [CountW-1:0] MaxCount = CountW'(MaxBits);

    // Command codes
    typedef enum logic [1:0] {
        OP_TX   = 2'd0,
        OP_RX   = 2'd1,
        OP_TICK = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    // Transfer mode
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TX   = 2'd1,
        MODE_RX   = 2'd2
    } t_mode;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_HALF_PERIOD = 1'b0,
        CFG_SELECT_MASK = 1'b1
    } t_cfg_idx;

    // One result beat
    typedef struct packed {
        logic             sclk;
        logic             mosi;
        logic [MaskW-1:0] chip_selects;
        logic             busy_res;
        logic             done_res;
        logic [DataW-1:0] rx_data;
        logic             error;
    } t_result;

    // Data bit carried by the current transfer bit
    function automatic logic [PosW-1:0] bit_pos(
        input logic              order_msb,
        input logic [CountW-1:0] total,
        input logic [CountW-1:0] done
    );
        logic [CountW-1:0] p;
        p = order_msb ? (total - CountW'(1) - done) : done;
        return p[PosW-1:0];
    endfunction

endpackage

FILE: rtl/spi_master_mode0_shifter.sv
// Each accepted command or tick beat yields a registered result beat.
// One beat per cycle while o_stall is low; the state updates in a single pass,
// and a two-entry output stage (result register plus skid) decouples the ports.
// Reset (synchronous, active low): idle, clock low, MOSI low, shift registers
// cleared, half period 1, all chip selects high, no result pending.
// Top level of the SPI mode 0 master shifter; uses spim0_pkg.

module spi_master_mode0_shifter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic [spim0_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [spim0_pkg::HalfW-1:0]   i_cfg_wdata,
    // Command / tick channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_operation,
    input  logic [spim0_pkg::DataW-1:0]   i_tx_data,
    input  logic [spim0_pkg::CountW-1:0]  i_bit_count,
    input  logic                          i_msb_first,
    input  logic                          i_miso_level,
    // Result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_sclk,
    output logic                          o_mosi,
    output logic [spim0_pkg::MaskW-1:0]   o_chip_selects,
    output logic                          o_busy_res,
    output logic                          o_done_res,
    output logic [spim0_pkg::DataW-1:0]   o_rx_data,
    output logic                          o_error
);
    import spim0_pkg::*;

    // Configuration registers
    logic [HalfW-1:0]  r_half_period;
    logic [MaskW-1:0]  r_select_mask;

    // Shifter state
    t_mode             r_mode,       n_mode;
    logic [DataW-1:0]  r_tx_shift,   n_tx_shift;
    logic [DataW-1:0]  r_rx_shift,   n_rx_shift;
    logic [CountW-1:0] r_bits_done,  n_bits_done;
    logic [CountW-1:0] r_bits_total, n_bits_total;
    logic              r_order_msb,  n_order_msb;
    logic              r_phase,      n_phase;
    logic [HalfW-1:0]  r_tick_count, n_tick_count;
    logic              r_mosi,       n_mosi;

    // Output stage
    t_result           r_out,  r_skid;
    logic              r_out_valid, r_skid_valid;
    t_result           n_res;

    logic              in_accept;
    logic              out_take;
    logic              err;
    logic              done;
    logic [HalfW-1:0]  hp;
    logic [HalfW-1:0]  tick_inc;
    logic              tick_fire;
    logic [CountW-1:0] count_sat;
    logic [PosW-1:0]   cur_pos;
    logic [PosW-1:0]   start_pos;

    assign in_accept = i_valid && !r_skid_valid;
    assign out_take  = r_out_valid && !i_stall;
    assign o_stall   = r_skid_valid;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HalfW'(1);
            r_select_mask <= {MaskW{1'b1}};
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_HALF_PERIOD: r_half_period <= i_cfg_wdata;
                CFG_SELECT_MASK: r_select_mask <= i_cfg_wdata[MaskW-1:0];
                default: ;
            endcase
        end
    end

    // Tick pacing and bit positions
    assign hp        = (r_half_period == '0) ? HalfW'(1) : r_half_period;
    assign tick_inc  = r_tick_count + HalfW'(1);
    assign tick_fire = (tick_inc >= hp) || (tick_inc == '0);
    assign count_sat = (i_bit_count > MaxCount) ? MaxCount : i_bit_count;
    assign cur_pos   = bit_pos(r_order_msb, r_bits_total, r_bits_done);
    assign start_pos = bit_pos(i_msb_first, count_sat, '0);

    // Next state of the shifter
    always_comb begin
        n_mode       = r_mode;
        n_tx_shift   = r_tx_shift;
        n_rx_shift   = r_rx_shift;
        n_bits_done  = r_bits_done;
        n_bits_total = r_bits_total;
        n_order_msb  = r_order_msb;
        n_phase      = r_phase;
        n_tick_count = r_tick_count;
        n_mosi       = r_mosi;
        err          = 1'b0;
        done         = 1'b0;
        case (t_op'(i_operation)) inside
            OP_TX, OP_RX: begin
                if (r_mode != MODE_IDLE || i_bit_count == '0) begin
                    err = 1'b1;
                end else begin
                    n_mode       = (t_op'(i_operation) == OP_TX) ? MODE_TX : MODE_RX;
                    n_tx_shift   = i_tx_data & DataMask;
                    n_bits_done  = '0;
                    n_bits_total = count_sat;
                    n_order_msb  = i_msb_first;
                    n_phase      = 1'b0;
                    n_tick_count = '0;
                    if (t_op'(i_operation) == OP_RX) begin
                        n_rx_shift = '0;
                    end else begin
                        n_mosi = n_tx_shift[start_pos];
                    end
                end
            end
            OP_TICK: begin
                if (r_mode != MODE_IDLE) begin
                    n_tick_count = tick_inc;
                    if (tick_fire) begin
                        n_tick_count = '0;
                        if (!r_phase) begin
                            // rising edge: sample MISO, count the bit
                            n_phase = 1'b1;
                            if (r_mode == MODE_RX && i_miso_level) begin
                                n_rx_shift[cur_pos] = 1'b1;
                            end
                            n_bits_done = r_bits_done + CountW'(1);
                        end else begin
                            // falling edge: finish or present the next bit
                            n_phase = 1'b0;
                            if (r_bits_done >= r_bits_total) begin
                                n_mode = MODE_IDLE;
                                done   = 1'b1;
                            end else if (r_mode == MODE_TX) begin
                                n_mosi = r_tx_shift[cur_pos];
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Build the result beat
    always_comb begin
        n_res.sclk         = (n_mode != MODE_IDLE) ? n_phase : 1'b0;
        n_res.mosi         = n_mosi;
        n_res.chip_selects = r_select_mask & CsMask;
        n_res.busy_res     = (n_mode != MODE_IDLE);
        n_res.done_res     = done;
        n_res.rx_data      = n_rx_shift;
        n_res.error        = err;
    end

    // Advance shifter state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_tx_shift   <= '0;
            r_rx_shift   <= '0;
            r_bits_done  <= '0;
            r_bits_total <= '0;
            r_order_msb  <= 1'b0;
            r_phase      <= 1'b0;
            r_tick_count <= '0;
            r_mosi       <= 1'b0;
        end else if (in_accept) begin
            r_mode       <= n_mode;
            r_tx_shift   <= n_tx_shift;
            r_rx_shift   <= n_rx_shift;
            r_bits_done  <= n_bits_done;
            r_bits_total <= n_bits_total;
            r_order_msb  <= n_order_msb;
            r_phase      <= n_phase;
            r_tick_count <= n_tick_count;
            r_mosi       <= n_mosi;
        end
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_take) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (in_accept) begin
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payloads
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_accept) begin
            if (!r_out_valid || out_take) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sclk         = r_out.sclk;
    assign o_mosi         = r_out.mosi;
    assign o_chip_selects = r_out.chip_selects;
    assign o_busy_res     = r_out.busy_res;
    assign o_done_res     = r_out.done_res;
    assign o_rx_data      = r_out.rx_data;
    assign o_error        = r_out.error;

endmodule

FILE: rtl/spim0_checker.sv
// Port-level checks for the SPI mode 0 master shifter, bound to the top level.
// Depends only on the top level's ports.

module spim0_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_sclk,
    input logic        o_busy_res,
    input logic        o_done_res,
    input logic [63:0] o_rx_data
);

    // Skid entry only fills behind a held result
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

    // A finished transfer leaves the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> !o_busy_res)
        else $error("done beat shows busy");

    // Clock high only inside a transfer
    a_sclk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sclk) |-> o_busy_res)
        else $error("sclk high while idle");

    // Held result beat keeps its data
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_rx_data)))
        else $error("stalled result beat changed");

endmodule

bind spi_master_mode0_shifter spim0_checker u_spim0_checker (.*);
